// File: rtl/core/sha256_pkg.sv
// shared types, constants and round functions for the sha-256 stream hasher
package sha256_pkg;

   localparam int unsigned NumRounds = 64;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenOffset = 56;
   localparam logic [7:0] PadByte = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } state_type;

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k [0:63];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };
      return k[idx];
   endfunction

   function automatic logic [31:0] init_word(input logic [2:0] idx);
      logic [31:0] h [0:7];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[idx];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
      return (v >> s) | (v << (32 - s));
   endfunction

endpackage

// File: rtl/core/sha256_if.sv
// valid/ready stream interfaces for request and response words
interface sha256_req_if (input logic clock);
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;
   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_rsp_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/core/sha256_stream_hasher.sv
// sha-256 stream hasher: one round per cycle on a single shared round unit
// a byte that does not complete a block is taken while idle; a byte that completes it
// keeps the input busy through all the rounds and the chaining add
// end of message: padding to the end of the block (a whole block after a full one),
// the length words, one or two compressed blocks, then 8 words at 1 per cycle when ready
// synchronous active-high reset restores the initial chaining value and clears counts
module sha256_stream_hasher
   import sha256_pkg::*;
(
   input logic         clock,
   input logic         reset,
   sha256_req_if.sink  req,
   sha256_rsp_if.source rsp
);

   state_type   state_ff, state_in;
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] var_ff [8];
   logic [31:0] var_in [8];
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic        fin_ff, fin_in;    // compression belongs to message end
   logic        two_ff, two_in;    // another final block follows
   logic        pad_ff, pad_in;    // padding of this message already written
   logic [2:0]  out_ff, out_in;

   logic [31:0] w15, w2, w7, g0, g1, wnew, s1, ch, s0, mj, t1;
   logic [3:0]  slot;

   always_comb begin
      slot = rnd_ff[3:0];
      w15 = win_ff[4'(slot + 4'd1)];
      w2 = win_ff[4'(slot + 4'd14)];
      w7 = win_ff[4'(slot + 4'd9)];
      g0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      g1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      wnew = (rnd_ff < 7'd16) ? win_ff[slot] : win_ff[slot] + g0 + w7 + g1;
      s1 = rotr(var_ff[4], 6) ^ rotr(var_ff[4], 11) ^ rotr(var_ff[4], 25);
      ch = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
      t1 = var_ff[7] + s1 + ch + round_const(rnd_ff[5:0]) + wnew;
      s0 = rotr(var_ff[0], 2) ^ rotr(var_ff[0], 13) ^ rotr(var_ff[0], 22);
      mj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
   end

   always_ff @(posedge clock) begin
      var_ff <= var_in;
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 8; i++) chain_ff[i] <= init_word(3'(i));
         fill_ff <= '0;
         len_ff <= '0;
         rnd_ff <= '0;
         fin_ff <= 1'b0;
         two_ff <= 1'b0;
         pad_ff <= 1'b0;
         out_ff <= '0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         fill_ff <= fill_in;
         len_ff <= len_in;
         rnd_ff <= rnd_in;
         fin_ff <= fin_in;
         two_ff <= two_in;
         pad_ff <= pad_in;
         out_ff <= out_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      var_in = var_ff;
      win_in = win_ff;
      fill_in = fill_ff;
      len_in = len_ff;
      rnd_in = rnd_ff;
      fin_in = fin_ff;
      two_in = two_ff;
      pad_in = pad_ff;
      out_in = out_ff;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.has_byte) begin
                  // bytes land big-endian straight in the schedule window
                  win_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = req.data_byte;
                  len_in = len_ff + 64'd8;
                  fill_in = 6'(fill_ff + 6'd1);
               end
               fin_in = req.end_of_message;
               if (req.has_byte && fill_ff == 6'(BlockBytes - 1)) begin
                  state_in = ST_ROUND;
                  rnd_in = '0;
                  var_in = chain_ff;
               end else if (req.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // write 0x80 then zeros up to the end of the block, one byte a cycle
            win_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] =
               (rnd_ff == 7'd0) ? PadByte : 8'h00;
            rnd_in = 7'(rnd_ff + 7'd1);
            fill_in = 6'(fill_ff + 6'd1);
            if (fill_ff == 6'(BlockBytes - 1)) begin
               pad_in = 1'b1;
               rnd_in = '0;
               fill_in = '0;
               if (rnd_ff > 7'(BlockBytes - 1 - LenOffset)) begin
                  two_in = 1'b0;
                  state_in = ST_LEN;
               end else begin
                  two_in = 1'b1;
                  state_in = ST_ROUND;
                  var_in = chain_ff;
               end
            end
         end
         ST_LEN: begin
            // final block: length in the last two words
            state_in = ST_ROUND;
            two_in = 1'b0;
            var_in = chain_ff;
            if (two_ff) begin
               for (int i = 0; i < 14; i++) win_in[i] = '0;
            end
            win_in[14] = len_ff[63:32];
            win_in[15] = len_ff[31:0];
         end
         ST_ROUND: begin
            if (rnd_ff == 7'(NumRounds)) begin
               for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + var_ff[i];
               rnd_in = '0;
               if (!fin_ff) begin
                  state_in = ST_IDLE;
               end else if (two_ff) begin
                  state_in = ST_LEN;
               end else if (pad_ff) begin
                  state_in = ST_OUT;
               end else begin
                  // a full block that ended the message still needs padding
                  state_in = ST_PAD;
               end
            end else begin
               win_in[slot] = wnew;
               var_in[7] = var_ff[6];
               var_in[6] = var_ff[5];
               var_in[5] = var_ff[4];
               var_in[4] = var_ff[3] + t1;
               var_in[3] = var_ff[2];
               var_in[2] = var_ff[1];
               var_in[1] = var_ff[0];
               var_in[0] = t1 + s0 + mj;
               rnd_in = 7'(rnd_ff + 7'd1);
            end
         end
         ST_OUT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               out_in = 3'(out_ff + 3'd1);
               if (out_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  for (int i = 0; i < 8; i++) chain_in[i] = init_word(3'(i));
                  len_in = '0;
                  fill_in = '0;
                  fin_in = 1'b0;
                  pad_in = 1'b0;
                  out_in = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.digest_word = chain_ff[out_ff];
   assign rsp.word_index = out_ff;
   assign rsp.last_word = (out_ff == 3'd7);

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("input and output active together");
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      rnd_ff <= 7'(NumRounds)) else $error("round counter out of range");
   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last_word |=> state_ff == ST_IDLE)
      else $error("digest did not end");
`endif

endmodule

// File: test/sha256_stream_hasher_checker.sv
// checker for the sha-256 stream hasher: watches both channels, predicts digests, compares
`timescale 1ns / 100ps
module sha256_stream_hasher_checker
   import sha256_pkg::*;
(
   input logic      clock,
   input logic      reset,
   sha256_req_if    req,
   sha256_rsp_if    rsp,
   output int       fail_count,
   output int       pending_words,
   output int       digests_done
);

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_item_type;

   digest_item_type digest_queue[$];

   logic [31:0] hash_state [0:7];
   logic [7:0]  msg_block [0:63];
   int          block_fill;
   logic [63:0] msg_bits;

   localparam logic [31:0] KTab [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] HInit [0:7] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
      32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] ror32(logic [31:0] v, int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   task automatic compress_msg_block();
      logic [31:0] w [0:63];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) begin
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
         w[i] = w[i-16] + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                  hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + KTab[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   task automatic restart_message();
      foreach (hash_state[i]) hash_state[i] = HInit[i];
      block_fill = 0;
      msg_bits = '0;
   endtask

   task automatic absorb_word(logic [7:0] data, logic has_byte, logic eom);
      digest_item_type d;
      if (has_byte) begin
         msg_block[block_fill] = data;
         block_fill++;
         msg_bits += 64'd8;
         if (block_fill == BlockBytes) begin
            compress_msg_block();
            block_fill = 0;
         end
      end
      if (eom) begin
         msg_block[block_fill] = PadByte;
         for (int i = block_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
         // no room for the length field: one extra block
         if (block_fill >= LenOffset) begin
            compress_msg_block();
            foreach (msg_block[i]) msg_block[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) msg_block[LenOffset + i] = msg_bits[63 - 8*i -: 8];
         compress_msg_block();
         for (int i = 0; i < 8; i++) begin
            d.digest_word = hash_state[i];
            d.word_index = i[2:0];
            d.last_word = (i == 7);
            digest_queue.push_back(d);
         end
         restart_message();
      end
   endtask

   initial begin
      fail_count = 0;
      digests_done = 0;
      pending_words = 0;
      restart_message();
   end

   always @(posedge clock) begin
      digest_item_type exp_w;
      if (reset) begin
         restart_message();
         digest_queue.delete();
      end else begin
         if (req.valid && req.ready) absorb_word(req.data_byte, req.has_byte, req.end_of_message);
         if (rsp.valid && rsp.ready) begin
            if (digest_queue.size() == 0) begin
               $error("unexpected digest word %h", rsp.digest_word);
               fail_count++;
            end else begin
               exp_w = digest_queue.pop_front();
               if (rsp.digest_word !== exp_w.digest_word) begin
                  $error("digest_word expected %h actual %h", exp_w.digest_word,
                         rsp.digest_word);
                  fail_count++;
               end
               if (rsp.word_index !== exp_w.word_index) begin
                  $error("word_index expected %0d actual %0d", exp_w.word_index,
                         rsp.word_index);
                  fail_count++;
               end
               if (rsp.last_word !== exp_w.last_word) begin
                  $error("last_word expected %0d actual %0d", exp_w.last_word,
                         rsp.last_word);
                  fail_count++;
               end
               if (exp_w.last_word) digests_done++;
            end
         end
      end
      pending_words = digest_queue.size();
   end

endmodule

// File: test/sha256_stream_hasher_tb.sv
// testbench top for the sha-256 stream hasher: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module sha256_stream_hasher_tb;

   localparam int WatchdogLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_words, digests_done;
   int   words_sent = 0;
   int   idle_cycles = 0;
   int   msg_count = 0;
   int   idle_pct = 28;
   logic hold_rsp = 1'b0;

   sha256_req_if req (clock);
   sha256_rsp_if rsp (clock);

   sha256_stream_hasher i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   sha256_stream_hasher_checker i_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .pending_words(pending_words), .digests_done(digests_done));

   always #2 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.data_byte = 8'h00;
      req.has_byte = 1'b0;
      req.end_of_message = 1'b0;
      rsp.ready = 1'b0;
   end

   // receiver: random stalls, plus one long hold-off while hold_rsp is set
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   initial begin
      wait (words_sent >= 60);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // watchdog on accepted words
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("FAIL sha256_stream_hasher");
         $finish;
      end
   end

   task automatic send_word(logic [7:0] data, logic has_byte, logic eom);
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data_byte <= data;
      req.has_byte <= has_byte;
      req.end_of_message <= eom;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      words_sent++;
      if (eom) msg_count++;
   endtask

   task automatic send_message(int len, logic empty_finish);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
         send_word(8'($urandom), 1'b1, !empty_finish && i == len - 1);
      end
      if (empty_finish || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   initial begin
      int len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: empty hash, "abc", byte extremes
      send_word(8'h00, 1'b0, 1'b1);
      send_word("a", 1'b1, 1'b0);
      send_word("b", 1'b1, 1'b0);
      send_word("c", 1'b1, 1'b1);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'hff, 1'b1, 1'b0);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'haa, 1'b1, 1'b0);
      send_word(8'h55, 1'b0, 1'b1);
      drain();
      // pause until all digests are back, then boundary lengths with no idling
      idle_pct = 0;
      send_message(55, 1'b0);
      send_message(56, 1'b0);
      send_message(64, 1'b1);
      idle_pct = 28;
      while (words_sent < 310) begin
         case ($urandom_range(3))
            0: len = $urandom_range(3);
            1: len = $urandom_range(54, 57);
            2: len = $urandom_range(63, 65);
            default: len = $urandom_range(30);
         endcase
         send_message(len, $urandom_range(3) == 0);
      end
      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d words in %0d messages, %0d digests checked",
               words_sent, msg_count, digests_done);
      if (fail_count == 0 && pending_words == 0) begin
         $display("PASS sha256_stream_hasher");
      end else begin
         $display("FAIL sha256_stream_hasher");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/sha256_pkg.sv
rtl/core/sha256_if.sv
rtl/core/sha256_stream_hasher.sv
test/sha256_stream_hasher_checker.sv
test/sha256_stream_hasher_tb.sv
